// File: hw/rtl/bsc_pkg.sv
// bright spot centroid: shared types and constants
// used by bsc_front, bsc_queue, bsc_back and bright_spot_centroid_core

package bsc_pkg;

  localparam int unsigned PixW    = 8;
  localparam int unsigned PosW    = 8;
  localparam int unsigned SumW    = 24;
  localparam int unsigned CountW  = 16;
  localparam int unsigned OffW    = 9;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 16;
  localparam int unsigned QuotW   = 8;

  localparam logic [SumW-1:0]   SumMax   = '1;
  localparam logic [CountW-1:0] CountMax = '1;

  // register indexes on the configuration channel
  typedef enum logic [CfgIdxW-1:0] {
    CfgThreshold = 2'd0,
    CfgMinCount  = 2'd1,
    CfgMaxCount  = 2'd2,
    CfgCenter    = 2'd3
  } cfg_idx_e;

  // one finished frame handed from the front to the back
  typedef struct packed {
    logic [SumW-1:0]   col_sum;
    logic [SumW-1:0]   row_sum;
    logic [CountW-1:0] count;
    logic [PosW-1:0]   center;
    logic              found;
  } job_t;

  // queue status seen by the top level and the back
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// File: hw/rtl/bright_spot_centroid_core.sv
// bright spot centroid core: top level with configuration registers and stream ports
// depends on bsc_pkg, bsc_front, bsc_queue and bsc_back
//
// usage
//   pixels of one frame enter in raster order on the slave stream, one transfer per
//   pixel; tlast marks the final pixel of the frame. the block tracks column and row
//   itself and sums the position of every pixel above the threshold.
//   after the final pixel one result transfer leaves on the master stream: tdata holds
//   the signed mean column and row minus center, tuser holds the found flag.
//   configuration writes go through the cfg channel (always ready) while idle.
// throughput and division
//   pixels are taken at one per cycle; the slave side stalls every pixel while the
//   two-entry job queue is full. the back runs a shared restoring divider,
//   one quotient bit per cycle for both means at once; a found result is registered
//   after the last quotient bit, a not-found result goes straight from idle to output.
// reset and back pressure
//   reset clears position, sums, count, queue and result; registers return to
//   threshold 250, min 20, max 1500, center 120. a stalled receiver holds the result,
//   further frames pile up in the queue, then the slave side deasserts tready.

module bright_spot_centroid_core import bsc_pkg::*; #(
  parameter int unsigned FRAME_WIDTH  = 240,
  parameter int unsigned FRAME_HEIGHT = 240
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // pixel stream
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [7:0]         s_axis_tdata_i,   // [7:0] pixel
  input  logic               s_axis_tlast_i,   // frame_end
  // result stream
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [23:0]        m_axis_tdata_o,   // [8:0] x_offset, [17:9] y_offset, zero fill
  output logic               m_axis_tuser_o,   // found
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDatW-1:0] cfg_data_i
);

  logic [PixW-1:0]   threshold_q;
  logic [CountW-1:0] min_count_q, max_count_q;
  logic [PosW-1:0]   center_q;

  logic              pix_fire;
  logic              push, pop;
  job_t              push_job, pop_job;
  queue_stat_t       qstat;
  logic signed [OffW-1:0] x_off, y_off;
  logic              found;

  // configuration registers, any index is written in one transfer
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= 8'd250;
      min_count_q <= 16'd20;
      max_count_q <= 16'd1500;
      center_q    <= 8'd120;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgThreshold: threshold_q <= cfg_data_i[PixW-1:0];
        CfgMinCount:  min_count_q <= cfg_data_i;
        CfgMaxCount:  max_count_q <= cfg_data_i;
        CfgCenter:    center_q    <= cfg_data_i[PosW-1:0];
        default: begin
          threshold_q <= threshold_q;
        end
      endcase
    end
  end

  // front keeps taking pixels as long as a finished frame has room in the queue
  assign s_axis_tready_o = !qstat.full;
  assign pix_fire        = s_axis_tvalid_i && s_axis_tready_o;

  bsc_front #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_fire_i  (pix_fire),
    .pixel_i     (s_axis_tdata_i),
    .frame_end_i (s_axis_tlast_i),
    .threshold_i (threshold_q),
    .min_count_i (min_count_q),
    .max_count_i (max_count_q),
    .center_i    (center_q),
    .push_o      (push),
    .job_o       (push_job)
  );

  // per-frame jobs wait here so pixels keep flowing while the divider runs
  bsc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .stat_o      (qstat)
  );

  bsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stat_i      (qstat),
    .job_i       (pop_job),
    .pop_o       (pop),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .x_off_o     (x_off),
    .y_off_o     (y_off),
    .found_o     (found)
  );

  // result packing, offsets in two's complement
  assign m_axis_tdata_o = {6'b0, y_off, x_off};
  assign m_axis_tuser_o = found;

endmodule

// File: hw/rtl/bsc_front.sv
// bright spot centroid front: raster position tracking and bright pixel accumulation
// depends on bsc_pkg; emits one job per frame into bsc_queue

module bsc_front import bsc_pkg::*; #(
  parameter int unsigned FRAME_WIDTH  = 240,
  parameter int unsigned FRAME_HEIGHT = 240
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pix_fire_i,
  input  logic [PixW-1:0]   pixel_i,
  input  logic              frame_end_i,
  input  logic [PixW-1:0]   threshold_i,
  input  logic [CountW-1:0] min_count_i,
  input  logic [CountW-1:0] max_count_i,
  input  logic [PosW-1:0]   center_i,
  output logic              push_o,
  output job_t              job_o
);

  localparam logic [PosW-1:0] ColLast = PosW'(FRAME_WIDTH - 1);
  localparam logic [PosW-1:0] RowLast = PosW'(FRAME_HEIGHT - 1);

  logic [PosW-1:0]   col_q, col_d, row_q, row_d;
  logic [SumW-1:0]   col_sum_q, col_sum_d, row_sum_q, row_sum_d;
  logic [CountW-1:0] count_q, count_d;
  logic [SumW:0]     col_add, row_add;
  logic              bright;

  assign bright  = pixel_i > threshold_i;
  assign col_add = {1'b0, col_sum_q} + (SumW+1)'(col_q);
  assign row_add = {1'b0, row_sum_q} + (SumW+1)'(row_q);

  always_comb begin
    col_sum_d = col_sum_q;
    row_sum_d = row_sum_q;
    count_d   = count_q;
    if (bright) begin
      col_sum_d = col_add[SumW] ? SumMax : col_add[SumW-1:0];
      row_sum_d = row_add[SumW] ? SumMax : row_add[SumW-1:0];
      if (count_q != CountMax) begin
        count_d = count_q + CountW'(1);
      end
    end
    if (col_q >= ColLast) begin
      col_d = '0;
      row_d = (row_q >= RowLast) ? '0 : row_q + PosW'(1);
    end else begin
      col_d = col_q + PosW'(1);
      row_d = row_q;
    end
  end

  assign push_o         = pix_fire_i && frame_end_i;
  assign job_o.col_sum  = col_sum_d;
  assign job_o.row_sum  = row_sum_d;
  assign job_o.count    = count_d;
  assign job_o.center   = center_i;
  assign job_o.found    = (count_d > min_count_i) && (count_d < max_count_i) &&
                          (count_d != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      col_sum_q <= '0;
      row_sum_q <= '0;
      count_q   <= '0;
    end else if (pix_fire_i) begin
      if (frame_end_i) begin
        col_q     <= '0;
        row_q     <= '0;
        col_sum_q <= '0;
        row_sum_q <= '0;
        count_q   <= '0;
      end else begin
        col_q     <= col_d;
        row_q     <= row_d;
        col_sum_q <= col_sum_d;
        row_sum_q <= row_sum_d;
        count_q   <= count_d;
      end
    end
  end

endmodule

// File: hw/rtl/bsc_queue.sv
// bright spot centroid job queue: two-entry fifo between front and back
// depends on bsc_pkg

module bsc_queue import bsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  job_t        push_data_i,
  input  logic        pop_i,
  output job_t        pop_data_o,
  output queue_stat_t stat_o
);

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;

  assign stat_o.full  = fill_q == 2'd2;
  assign stat_o.empty = fill_q == 2'd0;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

endmodule

// File: hw/rtl/bsc_back.sv
// bright spot centroid back: shared restoring divider for both means and result register
// depends on bsc_pkg; pops jobs from bsc_queue

module bsc_back import bsc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  queue_stat_t           stat_i,
  input  job_t                  job_i,
  output logic                  pop_o,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output logic signed [OffW-1:0] x_off_o,
  output logic signed [OffW-1:0] y_off_o,
  output logic                  found_o
);

  typedef enum logic [1:0] {StIdle, StDiv, StOut} state_e;

  state_e            state_q;
  logic [SumW-1:0]   rem_x_q, rem_y_q, div_q;
  logic [QuotW-1:0]  qx_q, qy_q, qx_d, qy_d;
  logic [2:0]        step_q;
  logic [PosW-1:0]   center_q;
  logic signed [OffW-1:0] x_q, y_q;
  logic              found_q;
  logic              ge_x, ge_y;

  assign ge_x = rem_x_q >= div_q;
  assign ge_y = rem_y_q >= div_q;
  assign qx_d = {qx_q[QuotW-2:0], ge_x};
  assign qy_d = {qy_q[QuotW-2:0], ge_y};

  assign pop_o       = (state_q == StIdle) && !stat_i.empty;
  assign res_valid_o = state_q == StOut;
  assign x_off_o     = x_q;
  assign y_off_o     = y_q;
  assign found_o     = found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      rem_x_q  <= '0;
      rem_y_q  <= '0;
      div_q    <= '0;
      qx_q     <= '0;
      qy_q     <= '0;
      step_q   <= '0;
      center_q <= '0;
      x_q      <= '0;
      y_q      <= '0;
      found_q  <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (!stat_i.empty) begin
            center_q <= job_i.center;
            found_q  <= job_i.found;
            if (job_i.found) begin
              // mean is below 256, so eight quotient bits cover it
              rem_x_q <= job_i.col_sum;
              rem_y_q <= job_i.row_sum;
              div_q   <= {1'b0, job_i.count, 7'b0};
              qx_q    <= '0;
              qy_q    <= '0;
              step_q  <= 3'd7;
              state_q <= StDiv;
            end else begin
              x_q     <= '0;
              y_q     <= '0;
              state_q <= StOut;
            end
          end
        end
        StDiv: begin
          if (ge_x) begin
            rem_x_q <= rem_x_q - div_q;
          end
          if (ge_y) begin
            rem_y_q <= rem_y_q - div_q;
          end
          qx_q   <= qx_d;
          qy_q   <= qy_d;
          div_q  <= div_q >> 1;
          step_q <= step_q - 3'd1;
          if (step_q == 3'd0) begin
            x_q     <= $signed({1'b0, qx_d}) - $signed({1'b0, center_q});
            y_q     <= $signed({1'b0, qy_d}) - $signed({1'b0, center_q});
            state_q <= StOut;
          end
        end
        StOut: begin
          if (res_ready_i) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

// File: dv/bright_spot_centroid_core_tb.sv
// testbench for bright_spot_centroid_core: pixel frames in, centroid offsets out
// depends on bsc_pkg and the core rtl; self-checking with its own centroid predictor
`timescale 1ns / 1ps

module bright_spot_centroid_core_tb;
  import bsc_pkg::*;

  // wide frame so the column reaches 239, short height so row wrap comes quickly
  localparam int unsigned FrameW       = 240;
  localparam int unsigned FrameH       = 3;
  localparam int unsigned DrainCycles  = 24;
  localparam int unsigned PressureHold = 300;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned RandomPixels = 550;
  localparam int unsigned RandomFrames = 10;

  typedef struct packed {
    logic signed [OffW-1:0] x_off;
    logic signed [OffW-1:0] y_off;
    logic                   found;
  } centroid_t;

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 s_valid   = 1'b0;
  logic [PixW-1:0]      s_data    = '0;
  logic                 s_last    = 1'b0;
  logic                 s_ready;
  logic                 m_valid;
  logic                 m_ready   = 1'b0;
  logic [23:0]          m_data;
  logic                 m_user;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  cfg_idx_e             cfg_index = CfgThreshold;
  logic [CfgDatW-1:0]   cfg_data  = '0;

  // predictor state and settings
  logic [PixW-1:0]      thr_q;
  logic [CountW-1:0]    min_q;
  logic [CountW-1:0]    max_q;
  logic [PosW-1:0]      center_q;
  int unsigned          col_pos;
  int unsigned          row_pos;
  int unsigned          col_acc;
  int unsigned          row_acc;
  int unsigned          hit_count;
  centroid_t            centroid_q[$];

  int unsigned          fail_count   = 0;
  int unsigned          pixels_sent  = 0;
  int unsigned          frames_sent  = 0;
  int unsigned          results_seen = 0;
  int unsigned          idle_cycles  = 0;
  int unsigned          hold_cycles  = 0;
  bit                   gaps_on      = 1'b1;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  bright_spot_centroid_core #(
    .FRAME_WIDTH  (FrameW),
    .FRAME_HEIGHT (FrameH)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  // predicts on every pixel transfer, checks every result transfer
  always @(posedge clk_i or negedge rst_ni) begin
    centroid_t   exp_c;
    int          dx;
    int          dy;
    if (!rst_ni) begin
      thr_q     = 8'd250;
      min_q     = 16'd20;
      max_q     = 16'd1500;
      center_q  = 8'd120;
      col_pos   = 0;
      row_pos   = 0;
      col_acc   = 0;
      row_acc   = 0;
      hit_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CfgThreshold: thr_q    = cfg_data[PixW-1:0];
          CfgMinCount:  min_q    = cfg_data;
          CfgMaxCount:  max_q    = cfg_data;
          CfgCenter:    center_q = cfg_data[PosW-1:0];
          default: ;
        endcase
      end

      if (s_valid && s_ready) begin
        if (s_data > thr_q) begin
          col_acc = (col_acc + col_pos > SumMax) ? SumMax : col_acc + col_pos;
          row_acc = (row_acc + row_pos > SumMax) ? SumMax : row_acc + row_pos;
          if (hit_count < CountMax) hit_count++;
        end
        if (col_pos >= FrameW - 1) begin
          col_pos = 0;
          row_pos = (row_pos >= FrameH - 1) ? 0 : row_pos + 1;
        end else begin
          col_pos++;
        end
        if (s_last) begin
          if (hit_count > min_q && hit_count < max_q && hit_count != 0) begin
            dx = int'(col_acc / hit_count) - int'(center_q);
            dy = int'(row_acc / hit_count) - int'(center_q);
            exp_c.x_off = dx[OffW-1:0];
            exp_c.y_off = dy[OffW-1:0];
            exp_c.found = 1'b1;
          end else begin
            exp_c = '0;
          end
          centroid_q.push_back(exp_c);
          col_pos   = 0;
          row_pos   = 0;
          col_acc   = 0;
          row_acc   = 0;
          hit_count = 0;
        end
      end

      if (m_valid && m_ready) begin
        results_seen++;
        if (centroid_q.size() == 0) begin
          $error("result transfer with no frame pending: tdata %h tuser %b", m_data, m_user);
          fail_count++;
        end else begin
          exp_c = centroid_q.pop_front();
          if ($signed(m_data[8:0]) !== exp_c.x_off) begin
            $error("x_offset: expected %0d, actual %0d", exp_c.x_off, $signed(m_data[8:0]));
            fail_count++;
          end
          if ($signed(m_data[17:9]) !== exp_c.y_off) begin
            $error("y_offset: expected %0d, actual %0d", exp_c.y_off, $signed(m_data[17:9]));
            fail_count++;
          end
          if (m_data[23:18] !== 6'd0) begin
            $error("tdata fill: expected 0, actual %0h", m_data[23:18]);
            fail_count++;
          end
          if (m_user !== exp_c.found) begin
            $error("found: expected %0d, actual %0d", exp_c.found, m_user);
            fail_count++;
          end
        end
      end

      if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
  end

  // longest legal quiet stretch is the receiver hold-off
  initial begin
    while (idle_cycles < StallLimit) @(posedge clk_i);
    $display("simulation failed");
    $finish;
  end

  // result side ready: random stall bursts, or one long hold when asked
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_cycles != 0) begin
        m_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
        m_ready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        m_ready <= 1'b1;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  task automatic send_pixel(input logic [PixW-1:0] value, input logic frame_end);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= value;
    s_last  <= frame_end;
    do @(posedge clk_i); while (!s_ready);
    pixels_sent++;
    if (frame_end) frames_sent++;
  endtask

  // style 0 uniform, 1 dark with sparse bright spots, else all white
  task automatic send_frame(input int unsigned len, input int unsigned style);
    logic [PixW-1:0] value;
    for (int unsigned i = 0; i < len; i++) begin
      case (style)
        0:       value = 8'($urandom_range(0, 255));
        1:       value = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(200, 255))
                                                      : 8'($urandom_range(0, 63));
        default: value = 8'hFF;
      endcase
      send_pixel(value, i == len - 1);
    end
  endtask

  // stop the pixel stream and let every pending frame come out
  task automatic wait_idle();
    s_valid <= 1'b0;
    while (results_seen < frames_sent) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDatW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  // byte-wide registers get random upper bits, which must be dropped
  task automatic set_config(input logic [7:0] thr, input logic [15:0] lo,
                            input logic [15:0] hi, input logic [7:0] ctr);
    write_reg(CfgThreshold, {8'($urandom), thr});
    write_reg(CfgMinCount, lo);
    write_reg(CfgMaxCount, hi);
    write_reg(CfgCenter, {8'($urandom), ctr});
    cfg_valid <= 1'b0;
  endtask

  // registers as they come out of reset; pixel equal to threshold is not bright
  task automatic test_default_registers();
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd250, 1'b0);
    send_pixel(8'd251, 1'b0);
    send_pixel(8'd255, 1'b1);
    send_frame(21, 2);
  endtask

  task automatic test_register_extremes();
    wait_idle();
    set_config(8'd0, 16'd0, 16'hFFFF, 8'd0);
    send_pixel(8'd1, 1'b1);
    send_pixel(8'd0, 1'b1);
    wait_idle();
    set_config(8'd255, 16'd0, 16'hFFFF, 8'd255);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd255, 1'b1);
    wait_idle();
    // mean zero against the largest center gives the most negative offset
    set_config(8'd100, 16'd0, 16'd2, 8'd255);
    send_pixel(8'd200, 1'b1);
  endtask

  task automatic test_window_edges();
    wait_idle();
    set_config(8'd100, 16'd5, 16'd5, 8'd120);
    send_frame(5, 2);
    wait_idle();
    set_config(8'd100, 16'd10, 16'd3, 8'd120);
    send_frame(3, 2);
  endtask

  // receiver holds off while short frames keep coming, so the job queue fills
  task automatic test_back_pressure();
    wait_idle();
    set_config(8'd128, 16'd0, 16'hFFFF, 8'd120);
    gaps_on = 1'b0;
    hold_cycles = PressureHold;
    repeat (16) send_frame(2, 2);
    wait_idle();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_frames();
    int unsigned pix_start;
    int unsigned frame_start;
    logic [7:0]  thr;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [7:0]  ctr;
    pix_start   = pixels_sent;
    frame_start = frames_sent;
    while (pixels_sent - pix_start < RandomPixels || frames_sent - frame_start < RandomFrames)
    begin
      wait_idle();
      gaps_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 5))
        0:       thr = 8'd0;
        1:       thr = 8'd255;
        default: thr = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 5))
        0:       lo = 16'd0;
        1:       lo = 16'hFFFF;
        2:       lo = 16'($urandom_range(0, 16'hFFFF));
        default: lo = 16'($urandom_range(0, 12));
      endcase
      case ($urandom_range(0, 5))
        0:       hi = 16'd0;
        1:       hi = 16'hFFFF;
        2:       hi = 16'($urandom_range(0, 16'hFFFF));
        default: hi = 16'($urandom_range(20, 400));
      endcase
      case ($urandom_range(0, 4))
        0:       ctr = 8'd0;
        1:       ctr = 8'd255;
        2:       ctr = 8'd239;
        default: ctr = 8'($urandom_range(0, 255));
      endcase
      set_config(thr, lo, hi, ctr);
      // mostly short frames; some run past line ends and wrap the row
      repeat ($urandom_range(2, 8)) begin
        if ($urandom_range(0, 11) == 0)
          send_frame($urandom_range(230, 760), $urandom_range(0, 2));
        else
          send_frame($urandom_range(1, 30), $urandom_range(0, 2));
      end
    end
  endtask

  task automatic test_quiet_tail();
    gaps_on = 1'b0;
    repeat (6) send_frame($urandom_range(1, 30), $urandom_range(0, 2));
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_default_registers();
    test_register_extremes();
    test_window_edges();
    test_back_pressure();
    test_random_frames();
    test_quiet_tail();
    wait_idle();
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
